// ===== rtl/pkmf_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and codes for the five-point cross mean filter.
// No dependencies; imported by pkmf_line_store and plus_kernel_mean_filter_rgb.
package pkmf_pkg;

   // Frame limits
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;

   // Field and counter widths
   localparam int CH_W    = 8;
   localparam int PIX_W   = 3 * CH_W;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int WID_W   = COL_W + 1;
   localparam int OROW_W  = $clog2(MAX_HEIGHT);
   localparam int HGT_W   = OROW_W + 1;
   localparam int IROW_W  = HGT_W;
   localparam int CSR_W   = HGT_W;
   localparam int SUM_W   = CH_W + 3;

   // Truncating divide by five: (s * DIV5_MUL) >> DIV5_SHIFT is exact for s < 2048
   localparam int DIV5_MUL   = 3277;
   localparam int DIV5_MUL_W = 12;
   localparam int DIV5_SHIFT = 14;

   // Register reset values, stored as dimension minus one
   localparam int WIDTH_RST  = 640;
   localparam int HEIGHT_RST = 480;

   typedef logic [COL_W-1:0] col_type;
   typedef logic [PIX_W-1:0] pixel_type;

   // Item kind carried on req_tuser
   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   // Configuration register indexes
   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // Line store read request: center column and right-neighbor column
   typedef struct packed {
      logic    en;
      col_type pcol;
      col_type col;
   } ls_rd_type;

   // Line store write request: shift one column of the row stores
   typedef struct packed {
      logic      en;
      col_type   addr;
      pixel_type data;
   } ls_wr_type;

endpackage

// ===== rtl/pkmf_line_store.sv =====
`timescale 1ns / 1ps
// Two row stores (upper and middle row) with registered reads and write forwarding.
// Depends on pkmf_pkg.
module pkmf_line_store
   import pkmf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  ls_rd_type rd,
   input  ls_wr_type wr,
   output pixel_type center,
   output pixel_type up,
   output pixel_type right
);

   pixel_type mid_mem   [MAX_WIDTH];
   pixel_type upper_mem [MAX_WIDTH];

   pixel_type mid_p_ff;
   pixel_type mid_c_ff;
   pixel_type up_p_ff;
   col_type   rd_pcol_ff;
   col_type   rd_col_ff;

   logic      fwd_valid_ff;
   col_type   fwd_addr_ff;
   pixel_type fwd_mid_ff;
   pixel_type fwd_up_ff;

   logic      hit_p;
   logic      hit_c;

   // Middle row: two read ports, one write port
   always_ff @(posedge clock) begin
      if (rd.en) begin
         mid_p_ff <= mid_mem[rd.pcol];
         mid_c_ff <= mid_mem[rd.col];
      end
      if (wr.en) begin
         mid_mem[wr.addr] <= wr.data;
      end
   end

   // Upper row: takes the old middle value of the same column
   always_ff @(posedge clock) begin
      if (rd.en) begin
         up_p_ff    <= upper_mem[rd.pcol];
         rd_pcol_ff <= rd.pcol;
         rd_col_ff  <= rd.col;
      end
      if (wr.en) begin
         upper_mem[wr.addr] <= center;
      end
   end

   // Remember the write that lands on the same edge as the next read
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= wr.en;
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff <= wr.addr;
      fwd_mid_ff  <= wr.data;
      fwd_up_ff   <= center;
   end

   // Bypass stale read data when the previous write hit the same column
   assign hit_p  = fwd_valid_ff && (fwd_addr_ff == rd_pcol_ff);
   assign hit_c  = fwd_valid_ff && (fwd_addr_ff == rd_col_ff);
   assign center = hit_p ? fwd_mid_ff : mid_p_ff;
   assign up     = hit_p ? fwd_up_ff  : up_p_ff;
   assign right  = hit_c ? fwd_mid_ff : mid_c_ff;

endmodule

// ===== rtl/plus_kernel_mean_filter_rgb.sv =====
`timescale 1ns / 1ps
// Five-point cross mean filter over an RGB raster stream: one pixel item per clock
// in, one filtered pixel per clock out. Each output channel is the truncated mean of
// the pixel and its up, down, left and right neighbors; neighbors outside the frame
// count as zero. A result trails its pixel by one row plus one pixel, so after the
// last pixel of a frame send frame_width + 1 drain items (req_tuser high) to flush
// the rest; rsp_tlast marks the final pixel, after which a new frame starts. A drain
// item sent while pixels are still due is taken and ignored, and a pixel sent after
// the frame's pixels acts as a drain. Writing frame_width or frame_height restarts
// the frame; write them only while no item is in flight. Widths above 2048 (from the
// low 12 bits of csr_wdata) and heights above 4096 are clamped, zero counts as one.
// The block sustains one item per cycle while the consumer keeps up: the middle row
// store is read at two columns and written at one in the cycle after an item is
// taken, with forwarding for back-to-back items on the same column. A result passes
// through the compute stage registers into a result slot, which raises rsp_tvalid.
// Three result slots decouple the consumer; req_tready drops while the results held
// plus the one being formed fill them, so only a stalled consumer slows the intake.
// Depends on pkmf_pkg and pkmf_line_store.
module plus_kernel_mean_filter_rgb
   import pkmf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // input items
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [PIX_W-1:0] req_tdata,   // red_in, green_in, blue_in
   input  logic             req_tuser,   // operation
   // result items
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [PIX_W-1:0] rsp_tdata,   // red_out, green_out, blue_out
   output logic             rsp_tlast,   // frame_last
   // configuration
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int QUEUE_DEPTH = 3;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic      last;
      pixel_type pix;
   } rsp_entry_type;

   function automatic logic [CH_W-1:0] div5(input logic [SUM_W-1:0] s);
      logic [SUM_W+DIV5_MUL_W-1:0] p;
      p = (SUM_W + DIV5_MUL_W)'(s) * (SUM_W + DIV5_MUL_W)'(DIV5_MUL);
      return p[DIV5_SHIFT +: CH_W];
   endfunction

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Configuration
   col_type             width_m1_ff;
   logic [OROW_W-1:0]   height_m1_ff;
   logic [WID_W-1:0]    wr_width;
   logic [HGT_W-1:0]    wr_height;
   col_type             width_m1_in;
   logic [OROW_W-1:0]   height_m1_in;

   // Frame position and window
   col_type             in_col_ff,  in_col_in;
   logic [IROW_W-1:0]   in_row_ff,  in_row_in;
   col_type             out_col_ff, out_col_in;
   logic [OROW_W-1:0]   out_row_ff, out_row_in;
   pixel_type           win0_ff,    win0_in;
   pixel_type           win1_ff;

   // Intake decode
   logic                accept;
   logic                drain;
   logic                frame_done;
   logic                take;
   logic                emit;
   logic                last;
   logic                store_wr;
   logic                finish;
   col_type             pcol;
   pixel_type           newpix;

   // Compute stage
   logic                s1_emit_ff;
   logic                s1_write_ff;
   col_type             s1_pcol_ff;
   pixel_type           s1_pend_ff;
   logic                s1_up_ok_ff;
   logic                s1_down_ok_ff;
   logic                s1_left_ok_ff;
   logic                s1_right_ok_ff;
   logic                s1_last_ff;

   ls_rd_type           ls_rd;
   ls_wr_type           ls_wr;
   pixel_type           ls_center;
   pixel_type           ls_up;
   pixel_type           ls_right;
   pixel_type           tap_up;
   pixel_type           tap_down;
   pixel_type           tap_left;
   pixel_type           tap_right;
   pixel_type           mean_pix;

   // Result queue
   rsp_entry_type       q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   q_wr_ptr_ff;
   logic [QPTR_W-1:0]   q_rd_ptr_ff;
   logic [QCNT_W-1:0]   q_count_ff;
   logic                push;
   logic                pop;

   // Clamp written dimensions to their legal range
   always_comb begin
      wr_width     = csr_wdata[WID_W-1:0];
      wr_height    = csr_wdata[HGT_W-1:0];
      width_m1_in  = width_m1_ff;
      height_m1_in = height_m1_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH: begin
               if (wr_width == '0) begin
                  width_m1_in = '0;
               end else if (wr_width > WID_W'(MAX_WIDTH)) begin
                  width_m1_in = COL_W'(MAX_WIDTH - 1);
               end else begin
                  width_m1_in = COL_W'(wr_width - 1'b1);
               end
            end
            CSR_FRAME_HEIGHT: begin
               if (wr_height == '0) begin
                  height_m1_in = '0;
               end else if (wr_height > HGT_W'(MAX_HEIGHT)) begin
                  height_m1_in = OROW_W'(MAX_HEIGHT - 1);
               end else begin
                  height_m1_in = OROW_W'(wr_height - 1'b1);
               end
            end
            default: begin
               width_m1_in  = width_m1_ff;
               height_m1_in = height_m1_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_m1_ff  <= COL_W'(WIDTH_RST - 1);
         height_m1_ff <= OROW_W'(HEIGHT_RST - 1);
      end else begin
         width_m1_ff  <= width_m1_in;
         height_m1_ff <= height_m1_in;
      end
   end

   // Decode the item at the intake
   assign accept     = req_tvalid && req_tready;
   assign drain      = (op_type'(req_tuser) == OP_DRAIN);
   assign frame_done = in_row_ff > IROW_W'(height_m1_ff);
   assign take       = accept && !(drain && !frame_done);
   assign pcol       = (in_col_ff == '0) ? width_m1_ff : in_col_ff - 1'b1;
   assign emit       = (in_row_ff >= IROW_W'(2)) ||
                       ((in_row_ff == IROW_W'(1)) && (in_col_ff != '0));
   assign last       = (out_row_ff == height_m1_ff) && (out_col_ff == width_m1_ff);
   assign store_wr   = (in_row_ff != '0) || (in_col_ff != '0);
   assign finish     = take && emit && last;
   assign newpix     = frame_done ? '0 : req_tdata;

   // Advance input and output positions; restart on frame end or config write
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      win0_in    = win0_ff;
      if (csr_we || finish) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         win0_in    = '0;
      end else if (take) begin
         if (emit) begin
            if (out_col_ff == width_m1_ff) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 1'b1;
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end
         win0_in = newpix;
         if (in_col_ff == width_m1_ff) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 1'b1;
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         win0_ff    <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         win0_ff    <= win0_in;
      end
   end

   // Hand the item to the compute stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_emit_ff  <= 1'b0;
         s1_write_ff <= 1'b0;
      end else begin
         s1_emit_ff  <= take && emit;
         s1_write_ff <= take && store_wr && !(emit && last);
      end
   end

   always_ff @(posedge clock) begin
      s1_pcol_ff     <= pcol;
      s1_pend_ff     <= win0_ff;
      s1_up_ok_ff    <= out_row_ff != '0;
      s1_down_ok_ff  <= out_row_ff != height_m1_ff;
      s1_left_ok_ff  <= out_col_ff != '0;
      s1_right_ok_ff <= out_col_ff != width_m1_ff;
      s1_last_ff     <= last;
   end

   // Row stores: read at intake, shift one column in the compute stage
   assign ls_rd.en   = accept;
   assign ls_rd.pcol = pcol;
   assign ls_rd.col  = in_col_ff;
   assign ls_wr.en   = s1_write_ff;
   assign ls_wr.addr = s1_pcol_ff;
   assign ls_wr.data = s1_pend_ff;

   pkmf_line_store u_line_store (
      .clock  (clock),
      .reset  (reset),
      .rd     (ls_rd),
      .wr     (ls_wr),
      .center (ls_center),
      .up     (ls_up),
      .right  (ls_right)
   );

   // Zero the taps that fall outside the frame
   assign tap_up    = s1_up_ok_ff    ? ls_up      : '0;
   assign tap_down  = s1_down_ok_ff  ? s1_pend_ff : '0;
   assign tap_left  = s1_left_ok_ff  ? win1_ff    : '0;
   assign tap_right = s1_right_ok_ff ? ls_right   : '0;

   // Sum the cross per channel and divide by five
   always_comb begin
      logic [SUM_W-1:0] sum;
      for (int k = 0; k < 3; k++) begin
         sum = SUM_W'(ls_center[k*CH_W +: CH_W]) + SUM_W'(tap_up[k*CH_W +: CH_W])
             + SUM_W'(tap_down[k*CH_W +: CH_W]) + SUM_W'(tap_left[k*CH_W +: CH_W])
             + SUM_W'(tap_right[k*CH_W +: CH_W]);
         mean_pix[k*CH_W +: CH_W] = div5(sum);
      end
   end

   // Keep the center as the next result's left neighbor
   always_ff @(posedge clock) begin
      if (s1_emit_ff) begin
         win1_ff <= ls_center;
      end
   end

   // Result queue decouples intake from the consumer
   assign push       = s1_emit_ff;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = q_count_ff != '0;
   assign rsp_tdata  = q_ff[q_rd_ptr_ff].pix;
   assign rsp_tlast  = q_ff[q_rd_ptr_ff].last;
   assign req_tready = ((QCNT_W + 1)'(q_count_ff) + (QCNT_W + 1)'(s1_emit_ff))
                       < (QCNT_W + 1)'(QUEUE_DEPTH);

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[q_wr_ptr_ff].pix  <= mean_pix;
         q_ff[q_wr_ptr_ff].last <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ptr_ff <= '0;
         q_rd_ptr_ff <= '0;
         q_count_ff  <= '0;
      end else begin
         if (push) begin
            q_wr_ptr_ff <= next_ptr(q_wr_ptr_ff);
         end
         if (pop) begin
            q_rd_ptr_ff <= next_ptr(q_rd_ptr_ff);
         end
         case ({push, pop})
            2'b10:   q_count_ff <= q_count_ff + 1'b1;
            2'b01:   q_count_ff <= q_count_ff - 1'b1;
            default: q_count_ff <= q_count_ff;
         endcase
      end
   end

`ifndef SYNTH
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (q_count_ff != QCNT_W'(QUEUE_DEPTH)) || pop)
      else $error("result pushed into full queue");

   a_input_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      in_col_ff <= width_m1_ff)
      else $error("input column beyond frame width");

   a_stage_from_intake: assert property (@(posedge clock) disable iff (reset)
      (s1_emit_ff || s1_write_ff) |-> $past(accept))
      else $error("compute stage active without an accepted item");

   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      (s1_emit_ff && s1_last_ff) |->
         (in_row_ff == '0) && (in_col_ff == '0) && (out_row_ff == '0))
      else $error("frame not restarted after last result");
`endif

endmodule
